@@ rtl/vlbc_pkg.sv @@
// package for the vehicle lamp blink controller: widths, action codes, register map
package vlbc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [7:0]            duty_t;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam duty_t FULL_DUTY = 8'd255;
    localparam logic [9:0] STRENGTH_ONE = 10'd256;
    localparam logic [3:0] PASS_INDEX_MAX = 4'd15;

    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_BRAKE    = 3'd1;
    localparam logic [2:0] ACT_TURN     = 3'd2;
    localparam logic [2:0] ACT_HEAD     = 3'd3;
    localparam logic [2:0] ACT_HAZARD   = 3'd4;
    localparam logic [2:0] ACT_PASSING  = 3'd5;

    localparam logic [1:0] DIR_OFF  = 2'd0;
    localparam logic [1:0] DIR_LEFT = 2'd1;

    localparam logic [2:0] REG_BRAKE_PERIOD = 3'd0;
    localparam logic [2:0] REG_BRAKE_ON     = 3'd1;
    localparam logic [2:0] REG_DIM_LEVEL    = 3'd2;
    localparam logic [2:0] REG_SPEED_THRESH = 3'd3;
    localparam logic [2:0] REG_TURN_HALF    = 3'd4;
    localparam logic [2:0] REG_PASS_HALF    = 3'd5;
    localparam logic [2:0] REG_PASS_FLASHES = 3'd6;

    function automatic timer_t sat_inc(timer_t v);
        sat_inc = (v == TIMER_MAX) ? TIMER_MAX : v + 1'b1;
    endfunction

endpackage

@@ rtl/vehicle_lamp_blink_controller.sv @@
// vehicle lamp blink controller: command and tick transactions in, lamp duty transactions out
//
//  channel  | signals                                              | direction
//  ---------+------------------------------------------------------+----------
//  command  | cmd_valid cmd_ready action enable brake_force        | in
//           | speed_mm_s turn_dir head_level                       |
//  duty     | duty_valid duty_ready front_duty left_duty           | out
//           | right_duty brake_duty                                |
//  config   | psel penable pwrite paddr pwdata prdata pready       | in/out
//
// one command per cycle while cmd_ready is high; its duties reach the output register next cycle
// the state update and lamp update form one combinational pass into the state and duty registers
// cmd_ready is low only while a duty transaction waits and duty_ready is low
// rst_n clears the lamp state and loads the register defaults at once
module vehicle_lamp_blink_controller
    import vlbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  logic [2:0]           action,
    input  logic                 enable,
    input  logic [9:0]           brake_force,
    input  logic [15:0]          speed_mm_s,
    input  logic [1:0]           turn_dir,
    input  logic [7:0]           head_level,
    output logic                 duty_valid,
    input  logic                 duty_ready,
    output logic [7:0]           front_duty,
    output logic [7:0]           left_duty,
    output logic [7:0]           right_duty,
    output logic [7:0]           brake_duty,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic [15:0] brake_period_reg;
    logic [15:0] brake_on_ms_reg;
    logic [7:0]  dim_level_reg;
    logic [15:0] speed_thresh_reg;
    logic [15:0] turn_half_reg;
    logic [15:0] pass_half_reg;
    logic [2:0]  pass_flashes_reg;

    logic        brake_on_reg,      brake_on_next;
    logic [9:0]  strength_reg,      strength_next;
    logic [15:0] speed_reg,         speed_next;
    timer_t      brake_ms_reg,      brake_ms_next;
    logic [1:0]  dir_reg,           dir_next;
    logic        blink_phase_reg,   blink_phase_next;
    timer_t      turn_ms_reg,       turn_ms_next;
    logic        hazard_on_reg,     hazard_on_next;
    logic [7:0]  head_reg,          head_next;
    logic        passing_on_reg,    passing_on_next;
    timer_t      pass_sub_reg,      pass_sub_next;
    logic [3:0]  pass_index_reg,    pass_index_next;

    logic        duty_valid_reg;
    duty_t       front_reg, left_reg, right_reg, brake_reg;
    duty_t       front_next, left_next, right_next, brake_next;

    logic        cmd_accept;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    duty_t       lit;

    assign cmd_ready  = !duty_valid_reg || duty_ready;
    assign cmd_accept = cmd_valid && cmd_ready;
    assign duty_valid = duty_valid_reg;
    assign front_duty = front_reg;
    assign left_duty  = left_reg;
    assign right_duty = right_reg;
    assign brake_duty = brake_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    // register read mux
    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            REG_BRAKE_PERIOD: prdata = {16'd0, brake_period_reg};
            REG_BRAKE_ON:     prdata = {16'd0, brake_on_ms_reg};
            REG_DIM_LEVEL:    prdata = {24'd0, dim_level_reg};
            REG_SPEED_THRESH: prdata = {16'd0, speed_thresh_reg};
            REG_TURN_HALF:    prdata = {16'd0, turn_half_reg};
            REG_PASS_HALF:    prdata = {16'd0, pass_half_reg};
            REG_PASS_FLASHES: prdata = {29'd0, pass_flashes_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_period_reg <= 16'd200;
            brake_on_ms_reg  <= 16'd100;
            dim_level_reg    <= 8'd13;
            speed_thresh_reg <= 16'd500;
            turn_half_reg    <= 16'd200;
            pass_half_reg    <= 16'd100;
            pass_flashes_reg <= 3'd3;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BRAKE_PERIOD: brake_period_reg <= pwdata[15:0];
                REG_BRAKE_ON:     brake_on_ms_reg  <= pwdata[15:0];
                REG_DIM_LEVEL:    dim_level_reg    <= pwdata[7:0];
                REG_SPEED_THRESH: speed_thresh_reg <= pwdata[15:0];
                REG_TURN_HALF:    turn_half_reg    <= pwdata[15:0];
                REG_PASS_HALF:    pass_half_reg    <= pwdata[15:0];
                REG_PASS_FLASHES: pass_flashes_reg <= pwdata[2:0];
                default:          ;
            endcase
        end
    end

    // command or tick first, then the lamp update on the new state
    always_comb
    begin
        brake_on_next    = brake_on_reg;
        strength_next    = strength_reg;
        speed_next       = speed_reg;
        brake_ms_next    = brake_ms_reg;
        dir_next         = dir_reg;
        blink_phase_next = blink_phase_reg;
        turn_ms_next     = turn_ms_reg;
        hazard_on_next   = hazard_on_reg;
        head_next        = head_reg;
        passing_on_next  = passing_on_reg;
        pass_sub_next    = pass_sub_reg;
        pass_index_next  = pass_index_reg;

        case (action)
            ACT_TICK:
            begin
                brake_ms_next = sat_inc(brake_ms_reg);
                turn_ms_next  = sat_inc(turn_ms_reg);
                if (passing_on_reg)
                begin
                    pass_sub_next = sat_inc(pass_sub_reg);
                    if (pass_sub_next >= pass_half_reg)
                    begin
                        pass_sub_next = '0;
                        if (pass_index_reg != PASS_INDEX_MAX)
                            pass_index_next = pass_index_reg + 4'd1;
                    end
                end
            end
            ACT_BRAKE:
            begin
                if (enable && !brake_on_reg)
                    brake_ms_next = '0;
                brake_on_next = enable;
                strength_next = brake_force;
                speed_next    = speed_mm_s;
            end
            ACT_TURN:
            begin
                if (turn_dir != dir_reg)
                begin
                    blink_phase_next = 1'b1;
                    turn_ms_next     = '0;
                end
                dir_next = turn_dir;
            end
            ACT_HEAD:
                head_next = head_level;
            ACT_HAZARD:
            begin
                if (enable && !hazard_on_reg)
                begin
                    blink_phase_next = 1'b1;
                    turn_ms_next     = '0;
                end
                hazard_on_next = enable;
            end
            ACT_PASSING:
            begin
                passing_on_next = 1'b1;
                pass_sub_next   = '0;
                pass_index_next = 4'd0;
            end
            default: ;
        endcase

        // brake lamp
        if (!brake_on_next)
            brake_next = dim_level_reg;
        else if (strength_next >= STRENGTH_ONE && speed_next > speed_thresh_reg)
        begin
            if (brake_ms_next >= brake_period_reg)
                brake_ms_next = '0;
            brake_next = (brake_ms_next < brake_on_ms_reg) ? FULL_DUTY : 8'd0;
        end
        else
            brake_next = FULL_DUTY;

        // turn and hazard lamps
        left_next  = 8'd0;
        right_next = 8'd0;
        lit        = 8'd0;
        if (hazard_on_next || dir_next != DIR_OFF)
        begin
            if (turn_ms_next >= turn_half_reg)
            begin
                blink_phase_next = !blink_phase_next;
                turn_ms_next     = '0;
            end
            lit = blink_phase_next ? FULL_DUTY : 8'd0;
            if (hazard_on_next)
            begin
                left_next  = lit;
                right_next = lit;
            end
            else if (dir_next == DIR_LEFT)
                left_next = lit;
            else
                right_next = lit;
        end

        // front lamp
        front_next = head_next;
        if (passing_on_next)
        begin
            if (pass_index_next >= {pass_flashes_reg, 1'b0})
                passing_on_next = 1'b0;
            else if (!pass_index_next[0])
                front_next = FULL_DUTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_on_reg    <= 1'b0;
            strength_reg    <= '0;
            speed_reg       <= '0;
            brake_ms_reg    <= '0;
            dir_reg         <= DIR_OFF;
            blink_phase_reg <= 1'b1;
            turn_ms_reg     <= '0;
            hazard_on_reg   <= 1'b0;
            head_reg        <= '0;
            passing_on_reg  <= 1'b0;
            pass_sub_reg    <= '0;
            pass_index_reg  <= '0;
        end
        else if (cmd_accept)
        begin
            brake_on_reg    <= brake_on_next;
            strength_reg    <= strength_next;
            speed_reg       <= speed_next;
            brake_ms_reg    <= brake_ms_next;
            dir_reg         <= dir_next;
            blink_phase_reg <= blink_phase_next;
            turn_ms_reg     <= turn_ms_next;
            hazard_on_reg   <= hazard_on_next;
            head_reg        <= head_next;
            passing_on_reg  <= passing_on_next;
            pass_sub_reg    <= pass_sub_next;
            pass_index_reg  <= pass_index_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_valid_reg <= 1'b0;
        else if (cmd_accept)
            duty_valid_reg <= 1'b1;
        else if (duty_ready)
            duty_valid_reg <= 1'b0;
    end

    // duty payload, loaded with each accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            front_reg <= front_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            brake_reg <= brake_next;
        end
    end

endmodule
